[hw/rtl/sbpb_pkg.sv]
package sbpb_pkg;

    // default column width
    localparam int COLUMN_BITS_DEF = 12;

    // pixel channel width
    localparam int CH_BITS = 8;

    // Q1.16 weight: 16 fraction bits plus the integer bit that holds 1.0
    localparam int FRAC_BITS = 16;
    localparam int WGT_BITS  = FRAC_BITS + 1;
    localparam logic [WGT_BITS-1:0] WGT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // squares of a Q1.16 value stay at or below 2^32
    localparam int SQ_BITS = 2 * FRAC_BITS + 1;

    // configuration register indexes
    localparam int CFG_ADDR_BITS = 1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HALF   = 1'b1;

    // one pixel pair
    typedef struct packed {
        logic [CH_BITS-1:0] base_r;
        logic [CH_BITS-1:0] base_g;
        logic [CH_BITS-1:0] base_b;
        logic [CH_BITS-1:0] over_r;
        logic [CH_BITS-1:0] over_g;
        logic [CH_BITS-1:0] over_b;
    } t_pix;

    // data carried alongside the weight computation
    typedef struct packed {
        logic force_hi;   // right of band: weight is 1.0
        logic force_lo;   // left of band or zero-width band: weight is 0
        t_pix pix;
    } t_side;

    // blended pixel
    typedef struct packed {
        logic [CH_BITS-1:0] out_b;
        logic [CH_BITS-1:0] out_g;
        logic [CH_BITS-1:0] out_r;
    } t_rgb;

endpackage

[hw/rtl/smooth_band_pixel_blend.sv]
// Blends a base and an overlay RGB pixel stream across a vertical band of columns,
// centered on center_column and half_band columns wide on each side: weight 0 left of
// the band, 1 right of it, and the smooth ramp t^2/(2t^2-2t+1) inside, in Q1.16.
// One pixel pair is taken every clock while the skid entry is empty. The pipeline is made up
// of band compare, the two pipelined restoring dividers (position and ramp, 17 stages
// each), two square/sum stages, two blend stages and the output register. A two-entry
// output buffer (output register and skid entry) catches a result that arrives while
// the output is held; the input stops taking pixels while the skid entry is full.
// Write configuration only when the pipeline is empty.
module smooth_band_pixel_blend #(
    parameter int COLUMN_BITS = sbpb_pkg::COLUMN_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input pixel pair
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // column, base_r, base_g, base_b, overlay_r, overlay_g, overlay_b; zero pad to bytes
    input  logic [((COLUMN_BITS+6*sbpb_pkg::CH_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // blended pixel
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // out_r, out_g, out_b
    output logic [3*sbpb_pkg::CH_BITS-1:0]         o_m_axis_tdata,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [sbpb_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [COLUMN_BITS-1:0]                 i_cfg_wdata
);

    localparam int CH = sbpb_pkg::CH_BITS;
    localparam int UB = $bits(sbpb_pkg::t_side);

    logic [COLUMN_BITS-1:0] r_center, r_half;
    logic                   en;

    logic [COLUMN_BITS-1:0] in_column;
    sbpb_pkg::t_pix         in_pix;

    logic                   band_valid;
    logic [COLUMN_BITS:0]   band_num, band_den;
    sbpb_pkg::t_side        band_side;

    logic                          t_valid;
    logic [sbpb_pkg::WGT_BITS-1:0] t_quo;
    logic [UB-1:0]                 t_user;

    logic                         sq_valid;
    logic [sbpb_pkg::SQ_BITS-1:0] sq_num, sq_den;
    sbpb_pkg::t_side              sq_side;

    logic                          w_valid;
    logic [sbpb_pkg::WGT_BITS-1:0] w_quo;
    logic [UB-1:0]                 w_user;

    logic           mix_valid;
    sbpb_pkg::t_rgb mix_rgb;

    logic           r_out_valid, r_skid_valid;
    sbpb_pkg::t_rgb r_out, r_skid;
    logic           take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_half   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sbpb_pkg::REG_CENTER: r_center <= i_cfg_wdata;
                sbpb_pkg::REG_HALF:   r_half   <= i_cfg_wdata;
                default:              r_half   <= r_half;
            endcase
        end
    end

    // unpack input tdata
    always_comb begin
        in_column     = i_s_axis_tdata[COLUMN_BITS-1:0];
        in_pix.base_r = i_s_axis_tdata[COLUMN_BITS+0*CH +: CH];
        in_pix.base_g = i_s_axis_tdata[COLUMN_BITS+1*CH +: CH];
        in_pix.base_b = i_s_axis_tdata[COLUMN_BITS+2*CH +: CH];
        in_pix.over_r = i_s_axis_tdata[COLUMN_BITS+3*CH +: CH];
        in_pix.over_g = i_s_axis_tdata[COLUMN_BITS+4*CH +: CH];
        in_pix.over_b = i_s_axis_tdata[COLUMN_BITS+5*CH +: CH];
    end

    // whole pipeline advances unless the skid entry is occupied
    assign en              = !r_skid_valid;
    assign o_s_axis_tready = en;

    sbpb_band #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_band (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_s_axis_tvalid),
        .i_column (in_column),
        .i_pix    (in_pix),
        .i_center (r_center),
        .i_half   (r_half),
        .o_valid  (band_valid),
        .o_num    (band_num),
        .o_den    (band_den),
        .o_side   (band_side)
    );

    // normalized position t
    sbpb_div #(
        .DEN_BITS  (COLUMN_BITS + 1),
        .QUO_BITS  (sbpb_pkg::WGT_BITS),
        .USER_BITS (UB)
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (band_valid),
        .i_num   (band_num),
        .i_den   (band_den),
        .i_user  (band_side),
        .o_valid (t_valid),
        .o_quo   (t_quo),
        .o_user  (t_user)
    );

    sbpb_sq u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (t_valid),
        .i_t     (t_quo),
        .i_side  (sbpb_pkg::t_side'(t_user)),
        .o_valid (sq_valid),
        .o_num   (sq_num),
        .o_den   (sq_den),
        .o_side  (sq_side)
    );

    // ramp weight w
    sbpb_div #(
        .DEN_BITS  (sbpb_pkg::SQ_BITS),
        .QUO_BITS  (sbpb_pkg::WGT_BITS),
        .USER_BITS (UB)
    ) u_div_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_num   (sq_num),
        .i_den   (sq_den),
        .i_user  (sq_side),
        .o_valid (w_valid),
        .o_quo   (w_quo),
        .o_user  (w_user)
    );

    sbpb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_valid),
        .i_w     (w_quo),
        .i_side  (sbpb_pkg::t_side'(w_user)),
        .o_valid (mix_valid),
        .o_rgb   (mix_rgb)
    );

    // output register with one skid entry
    assign take = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take || !r_out_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (mix_valid) begin
            if (take || !r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
        if (r_skid_valid) begin
            if (take || !r_out_valid) begin
                r_out <= r_skid;
            end
        end else if (mix_valid) begin
            if (take || !r_out_valid) begin
                r_out <= mix_rgb;
            end else begin
                r_skid <= mix_rgb;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // skid entry is only used behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // pipeline holds while the skid entry stays full
    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && $past(r_skid_valid)) |-> $stable(mix_valid))
        else $error("pipeline moved while stalled");

    // ramp weight never exceeds 1.0
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid |-> !(w_quo[sbpb_pkg::FRAC_BITS] && (w_quo[sbpb_pkg::FRAC_BITS-1:0] != '0)))
        else $error("ramp weight above one");

endmodule

[hw/rtl/sbpb_div.sv]
// Pipelined restoring divider: one quotient bit per stage, MSB first.
// Requires i_num <= i_den on entry; the remainder then stays below the divisor.
module sbpb_div #(
    parameter int DEN_BITS  = 13,
    parameter int QUO_BITS  = 17,
    parameter int USER_BITS = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [DEN_BITS-1:0]  i_num,
    input  logic [DEN_BITS-1:0]  i_den,
    input  logic [USER_BITS-1:0] i_user,
    output logic                 o_valid,
    output logic [QUO_BITS-1:0]  o_quo,
    output logic [USER_BITS-1:0] o_user
);

    logic                 r_vld  [QUO_BITS];
    logic [DEN_BITS-1:0]  r_rem  [QUO_BITS];
    logic [DEN_BITS-1:0]  r_den  [QUO_BITS];
    logic [QUO_BITS-1:0]  r_quo  [QUO_BITS];
    logic [USER_BITS-1:0] r_user [QUO_BITS];

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
        logic                 p_vld;
        logic [DEN_BITS:0]    p_cand;
        logic [DEN_BITS-1:0]  p_den;
        logic [QUO_BITS-1:0]  p_quo;
        logic [USER_BITS-1:0] p_user;
        logic                 ge;
        logic [DEN_BITS-1:0]  n_rem;
        logic [QUO_BITS-1:0]  n_quo;

        // first step compares the numerator as is, later steps shift the remainder
        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_cand = {1'b0, i_num};
            assign p_den  = i_den;
            assign p_quo  = '0;
            assign p_user = i_user;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_cand = {r_rem[k-1], 1'b0};
            assign p_den  = r_den[k-1];
            assign p_quo  = r_quo[k-1];
            assign p_user = r_user[k-1];
        end

        // trial subtract
        always_comb begin
            ge    = (p_cand >= {1'b0, p_den});
            n_rem = ge ? DEN_BITS'(p_cand - {1'b0, p_den}) : DEN_BITS'(p_cand);
            n_quo = {p_quo[QUO_BITS-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= p_den;
                r_quo[k]  <= n_quo;
                r_user[k] <= p_user;
            end
        end
    end

    assign o_valid = r_vld[QUO_BITS-1];
    assign o_quo   = r_quo[QUO_BITS-1];
    assign o_user  = r_user[QUO_BITS-1];

endmodule

[hw/rtl/sbpb_band.sv]
// Band edge compare and setup of the position division.
module sbpb_band #(
    parameter int COLUMN_BITS = sbpb_pkg::COLUMN_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [COLUMN_BITS-1:0] i_column,
    input  sbpb_pkg::t_pix         i_pix,
    input  logic [COLUMN_BITS-1:0] i_center,
    input  logic [COLUMN_BITS-1:0] i_half,
    output logic                   o_valid,
    output logic [COLUMN_BITS:0]   o_num,
    output logic [COLUMN_BITS:0]   o_den,
    output sbpb_pkg::t_side        o_side
);

    localparam int SW = COLUMN_BITS + 2;

    logic signed [SW-1:0] x, lo, hi, offs;
    logic                 left, right, zero, force_any;
    logic [COLUMN_BITS:0] n_num, n_den;

    logic                 r_valid;
    logic [COLUMN_BITS:0] r_num, r_den;
    sbpb_pkg::t_side      r_side;

    // signed band edges, lower edge may go negative
    always_comb begin
        x         = signed'({2'b00, i_column});
        lo        = signed'({2'b00, i_center}) - signed'({2'b00, i_half});
        hi        = signed'({2'b00, i_center}) + signed'({2'b00, i_half});
        offs      = x - lo;
        left      = (x < lo);
        right     = (x > hi);
        zero      = (i_half == '0);
        force_any = left || right || zero;
        // out of band or zero-width band: divide 0 by 1 so the divider stays in range
        n_num     = force_any ? '0 : offs[COLUMN_BITS:0];
        n_den     = force_any ? (COLUMN_BITS+1)'(1) : {i_half, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_num           <= n_num;
            r_den           <= n_den;
            r_side.force_hi <= right;
            r_side.force_lo <= left || zero;
            r_side.pix      <= i_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

[hw/rtl/sbpb_sq.sv]
// Ramp numerator and denominator: t^2 and t^2 + (1-t)^2 in Q1.32.
module sbpb_sq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [sbpb_pkg::WGT_BITS-1:0]   i_t,
    input  sbpb_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic [sbpb_pkg::SQ_BITS-1:0]    o_num,
    output logic [sbpb_pkg::SQ_BITS-1:0]    o_den,
    output sbpb_pkg::t_side                 o_side
);

    logic [sbpb_pkg::WGT_BITS-1:0] u;

    logic                          r_vld1, r_vld2;
    logic [sbpb_pkg::SQ_BITS-1:0]  r_tt, r_uu, r_num, r_den;
    sbpb_pkg::t_side               r_side1, r_side2;

    assign u = sbpb_pkg::WGT_ONE - i_t;

    // stage 1 squares, stage 2 sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
        if (i_en) begin
            r_tt    <= sbpb_pkg::SQ_BITS'(i_t * i_t);
            r_uu    <= sbpb_pkg::SQ_BITS'(u * u);
            r_side1 <= i_side;
            r_num   <= r_tt;
            r_den   <= sbpb_pkg::SQ_BITS'(r_tt + r_uu);
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_vld2;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_side  = r_side2;

endmodule

[hw/rtl/sbpb_mix.sv]
// Weight override and per-channel blend: base + floor((over - base) * w / 2^16).
module sbpb_mix (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [sbpb_pkg::WGT_BITS-1:0] i_w,
    input  sbpb_pkg::t_side               i_side,
    output logic                          o_valid,
    output sbpb_pkg::t_rgb                o_rgb
);

    localparam int PB = sbpb_pkg::CH_BITS + 1 + sbpb_pkg::WGT_BITS + 1;
    localparam int SB = sbpb_pkg::CH_BITS + 3;

    logic [sbpb_pkg::WGT_BITS-1:0] wf;
    logic signed [sbpb_pkg::WGT_BITS:0] ws;
    logic [sbpb_pkg::CH_BITS-1:0] base [3];
    logic [sbpb_pkg::CH_BITS-1:0] over [3];
    logic signed [sbpb_pkg::CH_BITS:0] dif [3];
    logic signed [PB-1:0] prod [3];
    logic signed [SB-1:0] sum [3];

    logic                         r_vld1, r_vld2;
    logic signed [PB-1:0]         r_prod [3];
    logic [sbpb_pkg::CH_BITS-1:0] r_base [3];
    sbpb_pkg::t_rgb               r_rgb;

    // stage 1: final weight and signed products
    always_comb begin
        priority if (i_side.force_hi) begin
            wf = sbpb_pkg::WGT_ONE;
        end else if (i_side.force_lo) begin
            wf = '0;
        end else begin
            wf = i_w;
        end
        ws      = signed'({1'b0, wf});
        base[0] = i_side.pix.base_r;
        base[1] = i_side.pix.base_g;
        base[2] = i_side.pix.base_b;
        over[0] = i_side.pix.over_r;
        over[1] = i_side.pix.over_g;
        over[2] = i_side.pix.over_b;
        for (int c = 0; c < 3; c++) begin
            dif[c]  = signed'({1'b0, over[c]}) - signed'({1'b0, base[c]});
            prod[c] = dif[c] * ws;
        end
    end

    // stage 2: floor shift and add back the base
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = signed'({3'b000, r_base[c]})
                   + SB'(r_prod[c] >>> sbpb_pkg::FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= prod[c];
                r_base[c] <= base[c];
            end
            r_rgb.out_r <= sum[0][sbpb_pkg::CH_BITS-1:0];
            r_rgb.out_g <= sum[1][sbpb_pkg::CH_BITS-1:0];
            r_rgb.out_b <= sum[2][sbpb_pkg::CH_BITS-1:0];
        end
    end

    assign o_valid = r_vld2;
    assign o_rgb   = r_rgb;

endmodule

[test/pixel_blend_checker.sv]
// Watches the pixel and config channels of the band blender, predicts each
// blended pixel from the transfers it sees and compares it with the output stream.
module pixel_blend_checker #(
    parameter int COLUMN_BITS = 12,
    parameter int S_BITS      = ((COLUMN_BITS + 6 * sbpb_pkg::CH_BITS + 7) / 8) * 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input pixel channel
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic [S_BITS-1:0]                      i_in_data,
    // output pixel channel
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic [3*sbpb_pkg::CH_BITS-1:0]         i_out_data,
    // config port
    input  logic                                   i_cfg_we,
    input  logic [sbpb_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [COLUMN_BITS-1:0]                 i_cfg_wdata,
    // status to the testbench top
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import sbpb_pkg::*;

    // local copy of the band registers
    logic [COLUMN_BITS-1:0] band_center = '0;
    logic [COLUMN_BITS-1:0] band_half   = '0;

    // blended pixels still owed by the block, oldest first
    t_rgb expected_rgb[$];
    int   fail_cnt = 0;

    // Q1.16 ramp weight for a column under the current band
    function automatic logic [WGT_BITS-1:0] ramp_q16(input logic [COLUMN_BITS-1:0] col);
        longint      x, hb, lo, hi;
        logic [63:0] t, tt, num, den;
        x  = col;
        hb = band_half;
        lo = longint'(band_center) - hb;
        hi = longint'(band_center) + hb;
        if (x < lo) return '0;         // left of band
        if (x > hi) return WGT_ONE;    // right of band
        if (hb == 0) return '0;        // zero-width band, column on the center
        t   = 64'((x - lo) << FRAC_BITS) / 64'(2 * hb);
        tt  = t * t;
        num = tt << FRAC_BITS;
        den = 64'd2 * tt + (64'd1 << 32) - 64'd2 * t * 64'd65536;
        return WGT_BITS'(num / den);
    endfunction

    // one channel: (base * (1 - w) + over * w) >> 16
    function automatic logic [CH_BITS-1:0] mix_q16(input logic [CH_BITS-1:0] base,
                                                  input logic [CH_BITS-1:0] over,
                                                  input logic [WGT_BITS-1:0] w);
        logic [63:0] v;
        v = (64'(base) * (64'd65536 - 64'(w)) + 64'(over) * 64'(w)) >> FRAC_BITS;
        return v[CH_BITS-1:0];
    endfunction

    // unpack one input transfer and blend it
    function automatic t_rgb predict_blend(input logic [S_BITS-1:0] d);
        t_rgb               r;
        logic [WGT_BITS-1:0] w;
        w = ramp_q16(d[COLUMN_BITS-1:0]);
        r.out_r = mix_q16(d[COLUMN_BITS +: CH_BITS], d[COLUMN_BITS + 3*CH_BITS +: CH_BITS], w);
        r.out_g = mix_q16(d[COLUMN_BITS + CH_BITS +: CH_BITS],
                          d[COLUMN_BITS + 4*CH_BITS +: CH_BITS], w);
        r.out_b = mix_q16(d[COLUMN_BITS + 2*CH_BITS +: CH_BITS],
                          d[COLUMN_BITS + 5*CH_BITS +: CH_BITS], w);
        return r;
    endfunction

    // sample all channels at the clock edge
    always @(posedge i_clk) begin : monitor_blk
        t_rgb got;
        t_rgb want;
        if (!i_rst_n) begin
            band_center = '0;
            band_half   = '0;
            expected_rgb.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_CENTER) band_center = i_cfg_wdata;
                else if (i_cfg_addr == REG_HALF) band_half = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready)
                expected_rgb.push_back(predict_blend(i_in_data));
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_rgb.size() == 0) begin
                    $error("blended pixel with none expected: %h", i_out_data);
                    fail_cnt++;
                end else begin
                    want = expected_rgb.pop_front();
                    if (got.out_r !== want.out_r) begin
                        $error("out_r: expected %0d, actual %0d", want.out_r, got.out_r);
                        fail_cnt++;
                    end
                    if (got.out_g !== want.out_g) begin
                        $error("out_g: expected %0d, actual %0d", want.out_g, got.out_g);
                        fail_cnt++;
                    end
                    if (got.out_b !== want.out_b) begin
                        $error("out_b: expected %0d, actual %0d", want.out_b, got.out_b);
                        fail_cnt++;
                    end
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_rgb.size();
    end

endmodule

[test/smooth_band_pixel_blend_tb.sv]
// Stimulus and verdict for the band blender; checking lives in pixel_blend_checker.
module smooth_band_pixel_blend_tb;
    import sbpb_pkg::*;

    localparam int COLUMN_BITS = 12;
    localparam int S_BITS      = ((COLUMN_BITS + 6 * CH_BITS + 7) / 8) * 8;
    localparam int MAX_COL     = (1 << COLUMN_BITS) - 1;
    localparam int FLUSH_CYC   = 60;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic [S_BITS-1:0]          s_data    = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b1;
    logic [3*CH_BITS-1:0]       m_data;
    logic                       cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0]   cfg_addr  = REG_CENTER;
    logic [COLUMN_BITS-1:0]     cfg_wdata = '0;
    int                         n_fail;
    int                         n_pending;
    bit                         calm      = 1'b0;

    always #4 clk = ~clk;

    smooth_band_pixel_blend #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    pixel_blend_checker #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (n_fail),
        .o_pending    (n_pending)
    );

    // one pixel pair transfer, with an optional idle burst in front
    task automatic send_pixel(input logic [COLUMN_BITS-1:0] col,
                              input logic [CH_BITS-1:0] br, input logic [CH_BITS-1:0] bg,
                              input logic [CH_BITS-1:0] bb, input logic [CH_BITS-1:0] ovr,
                              input logic [CH_BITS-1:0] ovg, input logic [CH_BITS-1:0] ovb);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {{(S_BITS - COLUMN_BITS - 6*CH_BITS){1'b0}}, ovb, ovg, ovr, bb, bg, br, col};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
    endtask

    // stop sending until every blended pixel is out, then let the pipe settle
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
        repeat (45) @(posedge clk);
    endtask

    // write both band registers while the block is idle
    task automatic set_band(input int c, input int h);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_CENTER;
        cfg_wdata <= COLUMN_BITS'(c);
        @(posedge clk);
        cfg_addr  <= REG_HALF;
        cfg_wdata <= COLUMN_BITS'(h);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // output side back-pressure in random bursts
    initial begin
        forever begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                m_ready <= 1'b1;
            end
        end
    end

    // hard stop
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int c;
        int h;
        int lo;
        int hi;
        int col;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset band: center 0, zero width
        send_pixel(0, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_pixel(1, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);

        // ordinary band 80..120: both edges, inside, outside, column extremes
        set_band(100, 20);
        send_pixel(0,       8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(79,      8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(80,      8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_pixel(90,      8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_pixel(100,     8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(110,     8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_pixel(120,     8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send_pixel(121,     8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_pixel(MAX_COL, 8'h12, 8'h34, 8'h56, 8'hAB, 8'hCD, 8'hEF);

        // zero-width band off center
        set_band(50, 0);
        send_pixel(49, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_pixel(50, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_pixel(51, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);

        // widest band, low edge far negative
        set_band(0, MAX_COL);
        send_pixel(0,       8'h00, 8'h80, 8'hFF, 8'hFF, 8'h80, 8'h00);
        send_pixel(MAX_COL, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h80, 8'h00);

        // widest band on the top column, high edge past the column range
        set_band(MAX_COL, MAX_COL);
        send_pixel(0,       8'hFF, 8'h7F, 8'h01, 8'h01, 8'h7F, 8'hFF);
        send_pixel(MAX_COL, 8'hFF, 8'h7F, 8'h01, 8'h01, 8'h7F, 8'hFF);

        // random phases, columns mostly aimed at the band
        for (int p = 0; p < 5; p++) begin
            c = $urandom_range(0, MAX_COL);
            case (p)
                0: h = $urandom_range(1, 8);
                1: h = 0;
                2: begin
                    c = MAX_COL;
                    h = $urandom_range(2000, MAX_COL);
                end
                3: h = $urandom_range(0, MAX_COL);
                default: h = $urandom_range(1, 300);
            endcase
            set_band(c, h);
            lo = c - h;
            hi = c + h;
            if (lo < 3) lo = 3;
            if (hi > MAX_COL - 3) hi = MAX_COL - 3;
            for (int k = 0; k < 100; k++) begin
                if (p == 3 && k == 50) drain_results();
                if (p == 4 && k == 40) calm <= 1'b1;
                if ($urandom_range(0, 9) < 7)
                    col = $urandom_range(lo - 3, hi + 3);
                else
                    col = $urandom_range(0, MAX_COL);
                send_pixel(COLUMN_BITS'(col),
                           CH_BITS'($urandom_range(0, 255)), CH_BITS'($urandom_range(0, 255)),
                           CH_BITS'($urandom_range(0, 255)), CH_BITS'($urandom_range(0, 255)),
                           CH_BITS'($urandom_range(0, 255)), CH_BITS'($urandom_range(0, 255)));
            end
        end

        // wait for the last pixels, then flush
        s_valid <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
        repeat (FLUSH_CYC) @(posedge clk);
        if (n_fail == 0 && n_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[smooth_band_pixel_blend.f]
hw/rtl/sbpb_pkg.sv
hw/rtl/sbpb_div.sv
hw/rtl/sbpb_band.sv
hw/rtl/sbpb_sq.sv
hw/rtl/sbpb_mix.sv
hw/rtl/smooth_band_pixel_blend.sv
test/pixel_blend_checker.sv
test/smooth_band_pixel_blend_tb.sv
